[rtl/dzos_pkg.sv]
// ----------------------------------------------------------------------------
// dzos_pkg
// Shared types and constants of the depth zone obstacle steering block.
// ----------------------------------------------------------------------------
package dzos_pkg;

	// payload widths
	localparam int DEPTH_W   = 16;
	localparam int ZONE_W    = 14;
	localparam int SPEED_W   = 14;
	localparam int TURN_W    = 16;
	localparam int CFG_W     = 13;
	localparam int CFG_IDX_W = 1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

	// configuration reset values and lower clamps
	localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 13'd640;
	localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 13'd480;
	localparam int               MIN_FRAME_W      = 6;
	localparam int               MIN_FRAME_H      = 4;

	// window bound slots
	localparam int BND_X0  = 0;
	localparam int BND_X1  = 1;
	localparam int BND_Y0  = 2;
	localparam int BND_Y1  = 3;
	localparam int BND_EL  = 4;
	localparam int BND_ER  = 5;
	localparam int BND_W   = 6;
	localparam int BND_H   = 7;
	localparam int BND_NUM = 8;

	// decision thresholds in mm
	localparam logic [ZONE_W-1:0]  NO_RANGE_MM  = 14'd10000;
	localparam logic [ZONE_W-1:0]  STOP_MM      = 14'd600;
	localparam logic [ZONE_W-1:0]  CAUTION_MM   = 14'd1200;
	localparam logic [ZONE_W-1:0]  DEAD_BAND_MM = 14'd250;

	// Q1.14 turn and Q0.14 speed command levels
	localparam logic [TURN_W-1:0]        Q14_ONE        = 16'd16384;
	localparam logic signed [TURN_W-1:0] TURN_LEFT_MAX  = 16'sd16384;
	localparam logic signed [TURN_W-1:0] TURN_RIGHT_MAX = -16'sd16384;
	localparam logic [SPEED_W-1:0]       CRUISE_SPEED   = 14'd12288;
	localparam logic [SPEED_W-1:0]       BASE_SPEED     = 14'd4096;
	localparam logic [SPEED_W-1:0]       STOP_SPEED     = 14'd0;

	// reciprocal multipliers: x/625 for x < 2^25, x/125 for x < 2^19
	localparam logic [25:0] DIV625_M = 26'd54975582;
	localparam int          DIV625_K = 35;
	localparam logic [19:0] DIV125_M = 20'd536871;
	localparam int          DIV125_K = 26;

	typedef struct packed {
		logic [ZONE_W-1:0] left;
		logic [ZONE_W-1:0] center;
		logic [ZONE_W-1:0] right;
	} zone_mins_t;

	typedef struct packed {
		logic [SPEED_W-1:0]       speed;
		logic signed [TURN_W-1:0] turn;
	} steer_cmd_t;

endpackage

[rtl/dzos_if.sv]
// ----------------------------------------------------------------------------
// dzos_if
// Valid/ready channels of the steering block: pixels, results, config writes.
// ----------------------------------------------------------------------------
interface dzos_pixel_if;
	logic                          valid;
	logic                          ready;
	logic [dzos_pkg::DEPTH_W-1:0]  depth_mm;
	logic                          depth_ok;
	logic                          frame_start;

	modport source (output valid, depth_mm, depth_ok, frame_start, input ready);
	modport sink   (input valid, depth_mm, depth_ok, frame_start, output ready);
endinterface

interface dzos_result_if;
	logic                                valid;
	logic                                ready;
	logic [dzos_pkg::SPEED_W-1:0]        forward_speed;
	logic signed [dzos_pkg::TURN_W-1:0]  turn_rate;
	logic [dzos_pkg::ZONE_W-1:0]         left_min_mm;
	logic [dzos_pkg::ZONE_W-1:0]         center_min_mm;
	logic [dzos_pkg::ZONE_W-1:0]         right_min_mm;

	modport source (output valid, forward_speed, turn_rate, left_min_mm, center_min_mm,
		right_min_mm, input ready);
	modport sink   (input valid, forward_speed, turn_rate, left_min_mm, center_min_mm,
		right_min_mm, output ready);
endinterface

interface dzos_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [dzos_pkg::CFG_IDX_W-1:0] reg_index;
	logic [dzos_pkg::CFG_W-1:0]     wr_data;

	modport source (output valid, reg_index, wr_data, input ready);
	modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

[rtl/dzos_window.sv]
// ----------------------------------------------------------------------------
// dzos_window
// Derives the window and zone edges from the frame size in three stages.
// ----------------------------------------------------------------------------
module dzos_window #(
	parameter int  MAX_FRAME_DIM = 4096,
	localparam int DIM_W         = $clog2(MAX_FRAME_DIM + 1)
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        cfg_write,
	input  logic [dzos_pkg::CFG_W-1:0]                  frame_width,
	input  logic [dzos_pkg::CFG_W-1:0]                  frame_height,
	output logic                                        busy,
	output logic [dzos_pkg::BND_NUM-1:0][DIM_W-1:0]     bounds
);

	localparam int     CMP_W = (DIM_W > dzos_pkg::CFG_W) ? DIM_W : dzos_pkg::CFG_W;
	localparam int     K3    = DIM_W + 2;
	localparam longint M3    = ((longint'(1) << K3) + 2) / 3;
	localparam int     P3    = DIM_W + K3;

	// x/3 by reciprocal, exact for x < 2^DIM_W
	function automatic logic [DIM_W-1:0] div3(input logic [DIM_W-1:0] x);
		logic [P3-1:0] p;
		p = P3'(x) * P3'(M3);
		return DIM_W'(p >> K3);
	endfunction

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [dzos_pkg::CFG_W-1:0] v,
		input logic [DIM_W-1:0] lo);
		logic [CMP_W-1:0] vx;
		vx = CMP_W'(v);
		if (vx > CMP_W'(MAX_FRAME_DIM)) begin
			return DIM_W'(MAX_FRAME_DIM);
		end else if (vx < CMP_W'(lo)) begin
			return lo;
		end
		return DIM_W'(vx);
	endfunction

	logic [2:0]       upd_q;
	logic [DIM_W-1:0] wc, hc;
	logic [DIM_W-1:0] w_s1, h_s1, cx_s1, hw_s1, cy_s1, hh_s1;
	logic [DIM_W-1:0] x0, x1, xs, y0, y1, ys, cw;
	logic [DIM_W-1:0] w_s2, h_s2, x0_s2, x1_s2, y0_s2, y1_s2, chalf_s2;
	logic [DIM_W-1:0] c6;

	// settle shift register: stages refill after reset or a write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upd_q <= 3'b111;
		end else begin
			upd_q <= {upd_q[1:0], cfg_write};
		end
	end

	assign busy = |upd_q;

	always_comb begin
		wc = clamp_dim(frame_width, DIM_W'(dzos_pkg::MIN_FRAME_W));
		hc = clamp_dim(frame_height, DIM_W'(dzos_pkg::MIN_FRAME_H));
	end

	always_ff @(posedge clk) begin
		w_s1  <= wc;
		h_s1  <= hc;
		cx_s1 <= wc >> 1;
		hw_s1 <= div3(wc) >> 1;
		cy_s1 <= hc >> 1;
		hh_s1 <= hc >> 2;
	end

	always_comb begin
		x0 = cx_s1 - hw_s1;
		xs = cx_s1 + hw_s1;
		x1 = (xs > w_s1) ? w_s1 : xs;
		y0 = cy_s1 - hh_s1;
		ys = cy_s1 + hh_s1;
		y1 = (ys > h_s1) ? h_s1 : ys;
		cw = x1 - x0;
	end

	always_ff @(posedge clk) begin
		w_s2     <= w_s1;
		h_s2     <= h_s1;
		x0_s2    <= x0;
		x1_s2    <= x1;
		y0_s2    <= y0;
		y1_s2    <= y1;
		chalf_s2 <= cw >> 1;
	end

	// c/6 taken as (c/2)/3
	assign c6 = div3(chalf_s2);

	always_ff @(posedge clk) begin
		bounds[dzos_pkg::BND_X0] <= x0_s2;
		bounds[dzos_pkg::BND_X1] <= x1_s2;
		bounds[dzos_pkg::BND_Y0] <= y0_s2;
		bounds[dzos_pkg::BND_Y1] <= y1_s2;
		bounds[dzos_pkg::BND_EL] <= chalf_s2 - c6;
		bounds[dzos_pkg::BND_ER] <= chalf_s2 + c6;
		bounds[dzos_pkg::BND_W]  <= w_s2;
		bounds[dzos_pkg::BND_H]  <= h_s2;
	end

endmodule

[rtl/dzos_decide.sv]
// ----------------------------------------------------------------------------
// dzos_decide
// Steering decision from the three zone minima: stop, caution or cruise.
// ----------------------------------------------------------------------------
module dzos_decide (
	input  dzos_pkg::zone_mins_t mins,
	output dzos_pkg::steer_cmd_t cmd
);

	logic [13:0]        l, c, r;
	logic               stop_c, caution_c, neg;
	logic [10:0]        gl, gr, cc;
	logic signed [11:0] dg;
	logic [10:0]        dg_mag;
	logic signed [14:0] d;
	logic [13:0]        d_mag;
	logic [24:0]        num_mag;
	logic [50:0]        tprod;
	logic [15:0]        q, q_sat;
	logic signed [15:0] prop_turn;
	logic [9:0]         cgap;
	logic [18:0]        snum;
	logic [44:0]        sprod;
	logic [13:0]        caut_speed;

	always_comb begin
		l = mins.left;
		c = mins.center;
		r = mins.right;

		stop_c    = c < dzos_pkg::STOP_MM;
		caution_c = (l < dzos_pkg::CAUTION_MM) || (r < dzos_pkg::CAUTION_MM);

		// caution gaps
		gl     = (l < dzos_pkg::CAUTION_MM) ? 11'(dzos_pkg::CAUTION_MM - l) : 11'd0;
		gr     = (r < dzos_pkg::CAUTION_MM) ? 11'(dzos_pkg::CAUTION_MM - r) : 11'd0;
		dg     = $signed({1'b0, gr}) - $signed({1'b0, gl});
		dg_mag = dg[11] ? 11'(-dg) : dg[10:0];

		// cruise difference
		d     = $signed({1'b0, l}) - $signed({1'b0, r});
		d_mag = d[14] ? 14'(-d) : d[13:0];

		// turn magnitude: gap*8192/625 or diff*2048/625, truncated
		num_mag = caution_c ? 25'({dg_mag, 13'b0}) : 25'({d_mag, 11'b0});
		neg     = caution_c ? dg[11] : d[14];
		tprod   = 51'(num_mag) * 51'(dzos_pkg::DIV625_M);
		q       = 16'(tprod >> dzos_pkg::DIV625_K);
		q_sat   = (q > dzos_pkg::Q14_ONE) ? dzos_pkg::Q14_ONE : q;
		prop_turn = neg ? -$signed(q_sat) : $signed(q_sat);

		// caution speed: base + (1200 - min(C,1200))*768/125
		cc         = (c < dzos_pkg::CAUTION_MM) ? c[10:0] : 11'(dzos_pkg::CAUTION_MM);
		cgap       = 10'(11'(dzos_pkg::CAUTION_MM) - cc);
		snum       = 19'({cgap, 9'b0}) + 19'({cgap, 8'b0});
		sprod      = 45'(snum) * 45'(dzos_pkg::DIV125_M);
		caut_speed = dzos_pkg::BASE_SPEED + 14'(sprod >> dzos_pkg::DIV125_K);

		if (stop_c) begin
			cmd.speed = dzos_pkg::STOP_SPEED;
			cmd.turn  = (l > r) ? dzos_pkg::TURN_LEFT_MAX : dzos_pkg::TURN_RIGHT_MAX;
		end else if (caution_c) begin
			cmd.speed = caut_speed;
			cmd.turn  = prop_turn;
		end else begin
			cmd.speed = dzos_pkg::CRUISE_SPEED;
			cmd.turn  = (d_mag < dzos_pkg::DEAD_BAND_MM) ? 16'sd0 : prop_turn;
		end
	end

endmodule

[rtl/depth_zone_obstacle_steering.sv]
// ----------------------------------------------------------------------------
// depth_zone_obstacle_steering
// Zone minima over a central depth window and one steering command per frame.
//
// Usage: depth pixels enter on the pixel channel in raster order, one request
// per pixel; the block counts columns and rows itself. frame_start on a
// pixel clears the counters and minima before that pixel is used. One
// request leaves on the steer channel for the last pixel of each frame,
// carrying speed, turn and the left, center and right minima.
// Throughput: one pixel per cycle while pixel ready is high. The last
// pixel's minima are registered in stage 1 and move on into the output
// register once it is free; the result is valid from there.
// Configuration: frame_width and frame_height are written on the cfg channel
// while the stream is idle; the window edges are rebuilt by a three-stage
// pipeline and pixel ready stays low after each write until it has refilled.
// Reset: counters clear, minima go to 10000 mm, sizes to 640x480, and pixel
// ready stays low while the window edges settle.
// Stall: a result waiting in the output register does not block pixels; one
// more result can wait in the stage ahead of it, and only when both are full
// does the result path hold pixel ready low.
// ----------------------------------------------------------------------------
module depth_zone_obstacle_steering #(
	parameter int MAX_FRAME_DIM = 4096
) (
	input  logic                 clk,
	input  logic                 arst_n,
	dzos_pixel_if.sink           pixel,
	dzos_result_if.source        steer,
	dzos_cfg_if.sink             cfg
);

	localparam int DIM_W = $clog2(MAX_FRAME_DIM + 1);
	localparam int CNT_W = $clog2(MAX_FRAME_DIM);

	// configuration registers
	logic [dzos_pkg::CFG_W-1:0] frame_width_q, frame_height_q;
	logic                       cfg_acc;

	// window edges
	logic                                    win_busy;
	logic [dzos_pkg::BND_NUM-1:0][DIM_W-1:0] bounds;

	// frame state
	logic [CNT_W-1:0]     col_q, row_q;
	dzos_pkg::zone_mins_t mins_q;

	// pixel path
	logic                 px_acc;
	logic [CNT_W-1:0]     col_e, row_e;
	dzos_pkg::zone_mins_t mins_e, mins_n;
	logic [DIM_W-1:0]     col_x, row_x, rx;
	logic [dzos_pkg::ZONE_W-1:0] depth_z;
	logic                 usable, in_win, last_col, frame_end;

	// result path
	logic                 s1_valid_s1, s1_move;
	dzos_pkg::zone_mins_t mins_s1;
	dzos_pkg::steer_cmd_t cmd;
	logic                 out_valid_q;

	localparam dzos_pkg::zone_mins_t MINS_CLEAR = '{
		left:   dzos_pkg::NO_RANGE_MM,
		center: dzos_pkg::NO_RANGE_MM,
		right:  dzos_pkg::NO_RANGE_MM
	};

	// ---------------------------------------------------------------- config
	// writes are always taken: the user must write only while the stream is idle
	assign cfg.ready = 1'b1;
	assign cfg_acc   = cfg.valid & cfg.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= dzos_pkg::FRAME_WIDTH_RST;
			frame_height_q <= dzos_pkg::FRAME_HEIGHT_RST;
		end else if (cfg_acc) begin
			case (cfg.reg_index)
				dzos_pkg::REG_FRAME_WIDTH:  frame_width_q  <= cfg.wr_data;
				dzos_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg.wr_data;
				default: ;
			endcase
		end
	end

	dzos_window #(
		.MAX_FRAME_DIM (MAX_FRAME_DIM)
	) u_window (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_acc),
		.frame_width  (frame_width_q),
		.frame_height (frame_height_q),
		.busy         (win_busy),
		.bounds       (bounds)
	);

	// ---------------------------------------------------------------- pixel
	// result stage may be refilled when it drains into the output register
	assign s1_move     = s1_valid_s1 & (~out_valid_q | steer.ready);
	assign pixel.ready = ~win_busy & (~s1_valid_s1 | s1_move);
	assign px_acc      = pixel.valid & pixel.ready;

	always_comb begin
		// frame_start clears before the pixel is used
		col_e  = pixel.frame_start ? '0 : col_q;
		row_e  = pixel.frame_start ? '0 : row_q;
		mins_e = pixel.frame_start ? MINS_CLEAR : mins_q;

		col_x   = DIM_W'(col_e);
		row_x   = DIM_W'(row_e);
		depth_z = dzos_pkg::ZONE_W'(pixel.depth_mm);

		// usable sample: finite and 1..10000 mm
		usable = pixel.depth_ok && (pixel.depth_mm != '0) &&
			(pixel.depth_mm <= dzos_pkg::DEPTH_W'(dzos_pkg::NO_RANGE_MM));
		in_win = (col_x >= bounds[dzos_pkg::BND_X0]) && (col_x < bounds[dzos_pkg::BND_X1]) &&
			(row_x >= bounds[dzos_pkg::BND_Y0]) && (row_x < bounds[dzos_pkg::BND_Y1]);
		rx = col_x - bounds[dzos_pkg::BND_X0];

		// running minimum of the zone this column falls in
		mins_n = mins_e;
		if (usable && in_win) begin
			if (rx < bounds[dzos_pkg::BND_EL]) begin
				if (depth_z < mins_e.left) mins_n.left = depth_z;
			end else if (rx > bounds[dzos_pkg::BND_ER]) begin
				if (depth_z < mins_e.right) mins_n.right = depth_z;
			end else begin
				if (depth_z < mins_e.center) mins_n.center = depth_z;
			end
		end

		// ">=" so counters left past a shrunk size still wrap
		last_col  = (col_x + DIM_W'(1)) >= bounds[dzos_pkg::BND_W];
		frame_end = last_col && ((row_x + DIM_W'(1)) >= bounds[dzos_pkg::BND_H]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			mins_q <= MINS_CLEAR;
		end else if (px_acc) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= frame_end ? '0 : row_e + CNT_W'(1);
			end else begin
				col_q <= col_e + CNT_W'(1);
				row_q <= row_e;
			end
			// next frame may begin without frame_start
			mins_q <= frame_end ? MINS_CLEAR : mins_n;
		end
	end

	// ---------------------------------------------------------------- result
	// stage 1 holds the final minima of a frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (px_acc && frame_end) begin
			s1_valid_s1 <= 1'b1;
		end else if (s1_move) begin
			s1_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (px_acc && frame_end) begin
			mins_s1 <= mins_n;
		end
	end

	dzos_decide u_decide (
		.mins (mins_s1),
		.cmd  (cmd)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_move) begin
			out_valid_q <= 1'b1;
		end else if (steer.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			steer.forward_speed <= cmd.speed;
			steer.turn_rate     <= cmd.turn;
			steer.left_min_mm   <= mins_s1.left;
			steer.center_min_mm <= mins_s1.center;
			steer.right_min_mm  <= mins_s1.right;
		end
	end

	assign steer.valid = out_valid_q;

	// ---------------------------------------------------------------- checks
	// no pixel may use half-rebuilt window edges
	a_cfg_blocks_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_acc |=> !px_acc)
		else $error("pixel taken right after a config write");

	// a pending frame result is never overwritten
	a_no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_s1 && !s1_move) |-> !(px_acc && frame_end))
		else $error("frame result lost in stage 1");

	// counters return to zero after a frame
	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(px_acc && frame_end) |=> (col_q == '0) && (row_q == '0) &&
		(mins_q == MINS_CLEAR))
		else $error("frame state not cleared after last pixel");

	// zone minima never exceed the 10000 mm no-range value
	a_mins_range: assert property (@(posedge clk) disable iff (!arst_n)
		(mins_q.left <= dzos_pkg::NO_RANGE_MM) && (mins_q.center <= dzos_pkg::NO_RANGE_MM) &&
		(mins_q.right <= dzos_pkg::NO_RANGE_MM))
		else $error("zone minimum out of range");

endmodule

[sim/depth_zone_obstacle_steering_tb.sv]
// ----------------------------------------------------------------------------
// depth_zone_obstacle_steering_tb
// Streams depth frames through the steering block and checks every result.
//
// Frames are built from per-zone floor depths so that the stop, caution and
// cruise cases, the dead band, the turn clamps and empty zones all come up.
// They are mixed with unusable samples, truncated frames and restarts. A
// predictor in the monitor tracks the pixel counters and zone minima of
// every accepted pixel request. Each frame end queues the expected steering
// request, and the monitor compares it field by field with what the block
// sends. The frame size is changed between phases, including sizes below
// the lower clamp on both registers.
// ----------------------------------------------------------------------------
module depth_zone_obstacle_steering_tb;

	localparam int FRAME_DIM_MAX     = 4096;
	localparam int CYCLE_LIMIT       = 2_000_000;
	localparam int RANDOM_PIXELS     = 1100;
	localparam int MIN_RANDOM_FRAMES = 12;
	localparam int NO_FLOOR          = -1;
	localparam int MAX_DEPTH_MM      = 10000;
	localparam int TURN_DIVISOR      = 5000;
	localparam int DRAIN_CYCLES      = 8;

	typedef enum logic [1:0] {ZN_OUT, ZN_LEFT, ZN_CENTER, ZN_RIGHT} zone_t;

	typedef struct {
		int w;
		int h;
		int x0;
		int x1;
		int y0;
		int y1;
		int el;
		int er;
	} window_t;

	typedef struct packed {
		logic [dzos_pkg::DEPTH_W-1:0] depth;
		logic                         ok;
		logic                         start;
	} pixel_t;

	typedef struct packed {
		logic [dzos_pkg::SPEED_W-1:0]       speed;
		logic signed [dzos_pkg::TURN_W-1:0] turn;
		logic [dzos_pkg::ZONE_W-1:0]        l;
		logic [dzos_pkg::ZONE_W-1:0]        c;
		logic [dzos_pkg::ZONE_W-1:0]        r;
	} steer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	dzos_pixel_if  pix ();
	dzos_result_if steer ();
	dzos_cfg_if    cfg ();

	depth_zone_obstacle_steering dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pixel  (pix),
		.steer  (steer),
		.cfg    (cfg)
	);

	// pending pixel requests and expected steering requests
	pixel_t pixel_queue[$];
	steer_t expected_steer[$];

	int errors = 0;
	int cycle_cnt = 0;

	// driver and receiver pacing
	logic pix_taken;
	int   burst_left = 0;
	int   gap_left = 0;
	int   stall_left = 0;

	// predictor state
	logic [dzos_pkg::CFG_W-1:0]  pred_width;
	logic [dzos_pkg::CFG_W-1:0]  pred_height;
	window_t                     pred_win;
	int                          col_cnt;
	int                          row_cnt;
	logic [dzos_pkg::ZONE_W-1:0] near_l;
	logic [dzos_pkg::ZONE_W-1:0] near_c;
	logic [dzos_pkg::ZONE_W-1:0] near_r;

	// generator view of the current frame geometry
	window_t gen_win;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int clamp_dim(input logic [dzos_pkg::CFG_W-1:0] v, input int lo);
		if (v < lo)
			return lo;
		if (v > FRAME_DIM_MAX)
			return FRAME_DIM_MAX;
		return v;
	endfunction

	// central window: middle third of the columns, middle half of the rows
	function automatic window_t window_of(input logic [dzos_pkg::CFG_W-1:0] wr,
		input logic [dzos_pkg::CFG_W-1:0] hr);
		window_t b;
		int      cx, hw, cy, hh, span;
		b.w = clamp_dim(wr, dzos_pkg::MIN_FRAME_W);
		b.h = clamp_dim(hr, dzos_pkg::MIN_FRAME_H);
		cx = b.w / 2;
		hw = (b.w / 3) / 2;
		cy = b.h / 2;
		hh = (b.h / 2) / 2;
		b.x0 = cx - hw;
		b.x1 = (cx + hw > b.w) ? b.w : cx + hw;
		b.y0 = cy - hh;
		b.y1 = (cy + hh > b.h) ? b.h : cy + hh;
		span = b.x1 - b.x0;
		b.el = span / 2 - span / 6;
		b.er = span / 2 + span / 6;
		return b;
	endfunction

	function automatic zone_t zone_of(input window_t b, input int col, input int row);
		int rx;
		if (col < b.x0 || col >= b.x1 || row < b.y0 || row >= b.y1)
			return ZN_OUT;
		rx = col - b.x0;
		if (rx < b.el)
			return ZN_LEFT;
		if (rx > b.er)
			return ZN_RIGHT;
		return ZN_CENTER;
	endfunction

	function automatic int clamp_turn(input int t);
		int one;
		one = dzos_pkg::Q14_ONE;
		if (t > one)
			return one;
		if (t < -one)
			return -one;
		return t;
	endfunction

	// steering decision from the three zone minima
	function automatic steer_t steer_decision(input logic [dzos_pkg::ZONE_W-1:0] l, c, r);
		steer_t s;
		int     li, ci, ri, stop_mm, caution_mm, dead_mm, gl, gr, cc, d, ad, t;
		li = l;
		ci = c;
		ri = r;
		stop_mm = dzos_pkg::STOP_MM;
		caution_mm = dzos_pkg::CAUTION_MM;
		dead_mm = dzos_pkg::DEAD_BAND_MM;
		s.l = l;
		s.c = c;
		s.r = r;
		if (ci < stop_mm) begin
			// obstacle dead ahead: stop and spin toward the farther side, tie turns right
			s.speed = dzos_pkg::STOP_SPEED;
			s.turn = (li > ri) ? dzos_pkg::TURN_LEFT_MAX : dzos_pkg::TURN_RIGHT_MAX;
		end else if (li < caution_mm || ri < caution_mm) begin
			// something close at a side: slow down and steer away from it
			gl = (li < caution_mm) ? caution_mm - li : 0;
			gr = (ri < caution_mm) ? caution_mm - ri : 0;
			cc = (ci < caution_mm) ? ci : caution_mm;
			t = clamp_turn(((gr - gl) * 65536) / TURN_DIVISOR);
			s.turn = dzos_pkg::TURN_W'(t);
			s.speed = dzos_pkg::SPEED_W'(int'(dzos_pkg::BASE_SPEED) +
				((caution_mm - cc) * 768) / 125);
		end else begin
			// open road: full speed, drift toward the farther side outside the dead band
			d = li - ri;
			ad = (d < 0) ? -d : d;
			s.speed = dzos_pkg::CRUISE_SPEED;
			if (ad < dead_mm)
				s.turn = '0;
			else begin
				t = clamp_turn((d * int'(dzos_pkg::Q14_ONE)) / TURN_DIVISOR);
				s.turn = dzos_pkg::TURN_W'(t);
			end
		end
		return s;
	endfunction

	task automatic clear_frame_state();
		col_cnt = 0;
		row_cnt = 0;
		near_l = dzos_pkg::NO_RANGE_MM;
		near_c = dzos_pkg::NO_RANGE_MM;
		near_r = dzos_pkg::NO_RANGE_MM;
	endtask

	// predictor step for one accepted pixel request
	task automatic track_pixel(input pixel_t p);
		if (p.start)
			clear_frame_state();
		if (p.ok && p.depth >= 1 && p.depth <= MAX_DEPTH_MM) begin
			case (zone_of(pred_win, col_cnt, row_cnt))
				ZN_LEFT: if (p.depth < near_l) near_l = dzos_pkg::ZONE_W'(p.depth);
				ZN_CENTER: if (p.depth < near_c) near_c = dzos_pkg::ZONE_W'(p.depth);
				ZN_RIGHT: if (p.depth < near_r) near_r = dzos_pkg::ZONE_W'(p.depth);
				default: ;
			endcase
		end
		// counters already past a shrunk size end the row or frame at once
		if (col_cnt + 1 >= pred_win.w) begin
			col_cnt = 0;
			if (row_cnt + 1 >= pred_win.h) begin
				expected_steer.push_back(steer_decision(near_l, near_c, near_r));
				clear_frame_state();
			end else
				row_cnt++;
		end else
			col_cnt++;
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk)
		cycle_cnt <= cycle_cnt + 1;

	always @(posedge clk)
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("%0t: run limit reached", $time);
			$display("[depth_zone_obstacle_steering] ERROR");
			$finish;
		end

	// monitor: results first, then the predictor for pixels and register writes
	always @(posedge clk or negedge arst_n) begin
		steer_t want;
		if (!arst_n) begin
			pix_taken <= 1'b0;
			pred_width = dzos_pkg::FRAME_WIDTH_RST;
			pred_height = dzos_pkg::FRAME_HEIGHT_RST;
			pred_win = window_of(dzos_pkg::FRAME_WIDTH_RST, dzos_pkg::FRAME_HEIGHT_RST);
			clear_frame_state();
		end else begin
			pix_taken <= pix.valid && pix.ready;
			if (steer.valid && steer.ready) begin
				if (expected_steer.size() == 0) begin
					errors++;
					$display("%0t: steer request with none expected, speed %0d turn %0d",
						$time, steer.forward_speed, steer.turn_rate);
				end else begin
					want = expected_steer.pop_front();
					check_field("forward_speed", want.speed, steer.forward_speed);
					check_field("turn_rate", want.turn, steer.turn_rate);
					check_field("left_min_mm", want.l, steer.left_min_mm);
					check_field("center_min_mm", want.c, steer.center_min_mm);
					check_field("right_min_mm", want.r, steer.right_min_mm);
				end
			end
			if (pix.valid && pix.ready)
				track_pixel(pixel_t'{depth: pix.depth_mm, ok: pix.depth_ok,
					start: pix.frame_start});
			if (cfg.valid && cfg.ready) begin
				// window edges follow every register write
				if (cfg.reg_index == dzos_pkg::REG_FRAME_WIDTH)
					pred_width = cfg.wr_data;
				else
					pred_height = cfg.wr_data;
				pred_win = window_of(pred_width, pred_height);
			end
		end
	end

	// pixel driver: bursts of requests with random gaps in between
	always @(negedge clk) begin
		pixel_t nxt;
		if (pix.valid && !pix_taken) begin
			// request still waiting for ready, hold it
		end else if (gap_left > 0) begin
			pix.valid <= 1'b0;
			gap_left <= gap_left - 1;
		end else if (pixel_queue.size() != 0) begin
			nxt = pixel_queue.pop_front();
			pix.valid <= 1'b1;
			pix.depth_mm <= nxt.depth;
			pix.depth_ok <= nxt.ok;
			pix.frame_start <= nxt.start;
			if (burst_left <= 1) begin
				burst_left <= $urandom_range(1, 48);
				// some bursts run straight into the next one
				gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			end else
				burst_left <= burst_left - 1;
		end else
			pix.valid <= 1'b0;
	end

	// result receiver: random stalls, stall-free whenever cycle_cnt[9:7] is zero
	always @(negedge clk) begin
		if (cycle_cnt[9:7] == 3'd0)
			steer.ready <= 1'b1;
		else if (stall_left > 0) begin
			steer.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 5) == 0) begin
			steer.ready <= 1'b0;
			stall_left <= $urandom_range(0, 30);
		end else
			steer.ready <= 1'b1;
	end

	task automatic write_reg(input logic [dzos_pkg::CFG_IDX_W-1:0] idx,
		input logic [dzos_pkg::CFG_W-1:0] data);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.reg_index <= idx;
		cfg.wr_data <= data;
		do @(posedge clk); while (!cfg.ready);
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	task automatic set_frame_size(input logic [dzos_pkg::CFG_W-1:0] w,
		input logic [dzos_pkg::CFG_W-1:0] h);
		// pick the write order at random so either register can land last
		if ($urandom_range(0, 1)) begin
			write_reg(dzos_pkg::REG_FRAME_WIDTH, w);
			write_reg(dzos_pkg::REG_FRAME_HEIGHT, h);
		end else begin
			write_reg(dzos_pkg::REG_FRAME_HEIGHT, h);
			write_reg(dzos_pkg::REG_FRAME_WIDTH, w);
		end
		gen_win = window_of(w, h);
	endtask

	// wait for all pixels taken and all results seen, then let the pipe drain
	task automatic wait_idle();
		do @(posedge clk);
		while (pixel_queue.size() != 0 || pix.valid || expected_steer.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic int pick_floor();
		case ($urandom_range(0, 9))
			0: return NO_FLOOR;
			1: return 1;
			2: return $urandom_range(1, 599);
			3: return $urandom_range(599, 600);
			4: return $urandom_range(1199, 1200);
			5: return $urandom_range(600, 1199);
			9: return MAX_DEPTH_MM;
			default: return $urandom_range(1200, MAX_DEPTH_MM);
		endcase
	endfunction

	// queue one frame (or its first len pixels); each zone draws usable depths
	// from its floor up to floor + spread, the rest is unusable noise
	task automatic push_frame(input int fl, input int fc, input int fr, input int spread,
		input int noise_pct, input int len, input bit start);
		pixel_t p;
		zone_t  z;
		int     col, row, floor_mm, top;
		for (int i = 0; i < len; i++) begin
			col = i % gen_win.w;
			row = i / gen_win.w;
			z = zone_of(gen_win, col, row);
			case (z)
				ZN_LEFT: floor_mm = fl;
				ZN_CENTER: floor_mm = fc;
				ZN_RIGHT: floor_mm = fr;
				default: floor_mm = NO_FLOOR;
			endcase
			p.start = start && i == 0;
			if (z != ZN_OUT && floor_mm != NO_FLOOR && $urandom_range(1, 100) > noise_pct) begin
				top = (floor_mm + spread > MAX_DEPTH_MM) ? MAX_DEPTH_MM : floor_mm + spread;
				p.ok = 1'b1;
				p.depth = dzos_pkg::DEPTH_W'($urandom_range(floor_mm, top));
			end else if (z == ZN_OUT && $urandom_range(0, 1)) begin
				// outside the window anything goes
				p.ok = 1'($urandom_range(0, 1));
				p.depth = dzos_pkg::DEPTH_W'($urandom);
			end else begin
				case ($urandom_range(0, 2))
					0: begin
						p.ok = 1'b0;
						p.depth = dzos_pkg::DEPTH_W'($urandom);
					end
					1: begin
						p.ok = 1'b1;
						p.depth = '0;
					end
					default: begin
						p.ok = 1'b1;
						p.depth = dzos_pkg::DEPTH_W'($urandom_range(MAX_DEPTH_MM + 1, 65535));
					end
				endcase
			end
			pixel_queue.push_back(p);
		end
	endtask

	// random frame with broken-sequence noise; returns pixels queued
	task automatic push_random_frame(output int pushed);
		int  fl, fc, fr, n, spread, cut;
		bit  start;
		n = gen_win.w * gen_win.h;
		fl = pick_floor();
		fc = pick_floor();
		fr = pick_floor();
		// left and right close together to probe the dead band edge
		if ($urandom_range(0, 3) == 0 && fl != NO_FLOOR) begin
			fr = fl + ($urandom_range(0, 1) ? 1 : -1) * $urandom_range(245, 255);
			if (fr < 1)
				fr = 1;
			if (fr > MAX_DEPTH_MM)
				fr = MAX_DEPTH_MM;
		end
		spread = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 400);
		pushed = 0;
		start = $urandom_range(0, 3) != 0;
		// truncated frame, then a restart with frame_start mid-stream
		if ($urandom_range(0, 9) == 0 && n > 1) begin
			cut = $urandom_range(1, n - 1);
			push_frame(fl, fc, fr, spread, 10, cut, start);
			pushed += cut;
			start = 1'b1;
		end
		push_frame(fl, fc, fr, spread, 10, n, start);
		pushed += n;
	endtask

	initial begin
		int dir_l[10] = '{NO_FLOOR, 1, 10000, 1, 1199, 10000, 1200, 5000, 5250, 1200};
		int dir_c[10] = '{NO_FLOOR, 599, 1, 1200, 600, 2000, 5000, 5000, 5000, 10000};
		int dir_r[10] = '{NO_FLOOR, 1, 1, 10000, 1200, 1200, 10000, 5249, 5000, 1200};
		int rand_pixels, rand_frames, nfr, pushed;

		pix.valid = 1'b0;
		pix.depth_mm = '0;
		pix.depth_ok = 1'b0;
		pix.frame_start = 1'b0;
		steer.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.reg_index = dzos_pkg::REG_FRAME_WIDTH;
		cfg.wr_data = '0;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (DRAIN_CYCLES) @(posedge clk);

		// directed frames on a 12x4 grid with two left, one center and one right column:
		// empty zones, stop with tie and with left farther, caution at the extremes,
		// cruise turn clamps both ways, dead band just inside and just outside
		set_frame_size(13'd12, 13'd4);
		for (int i = 0; i < 10; i++)
			push_frame(dir_l[i], dir_c[i], dir_r[i], 0, 0, gen_win.w * gen_win.h, 1'b1);
		wait_idle();

		// random phases, mostly small frames so results come often
		rand_pixels = 0;
		rand_frames = 0;
		while (rand_pixels < RANDOM_PIXELS || rand_frames < MIN_RANDOM_FRAMES) begin
			case ($urandom_range(0, 5))
				0: set_frame_size('0, '0);
				1: set_frame_size(dzos_pkg::CFG_W'($urandom_range(0, 5)),
					dzos_pkg::CFG_W'($urandom_range(0, 3)));
				default: set_frame_size(dzos_pkg::CFG_W'($urandom_range(6, 20)),
					dzos_pkg::CFG_W'($urandom_range(4, 9)));
			endcase
			nfr = $urandom_range(2, 5);
			for (int f = 0; f < nfr; f++) begin
				push_random_frame(pushed);
				rand_pixels += pushed;
				rand_frames++;
			end
			wait_idle();
		end

		if (errors == 0)
			$display("[depth_zone_obstacle_steering] OK");
		else
			$display("[depth_zone_obstacle_steering] ERROR");
		$finish;
	end

endmodule

[filelist.f]
rtl/dzos_pkg.sv
rtl/dzos_if.sv
rtl/dzos_window.sv
rtl/dzos_decide.sv
rtl/depth_zone_obstacle_steering.sv
sim/depth_zone_obstacle_steering_tb.sv
